/* rtl/core/stcs_pkg.sv */
// stcs_pkg: request types, result codes and fixed sizes of the challenge sampler
// no dependencies; used by sparse_ternary_challenge_sampler
package stcs_pkg;

  localparam int unsigned Degree      = 512;
  localparam int unsigned Weight      = 19;
  localparam int unsigned SignBytes   = 8;
  localparam int unsigned BufferBytes = 84;

  localparam int unsigned PosW   = 9;
  localparam int unsigned CoeffW = 63;
  localparam int unsigned CountW = 5;
  localparam int unsigned IdxW   = 7;

  // occupancy store: one row holds RowBits positions
  localparam int unsigned RowBits = 16;
  localparam int unsigned RowSelW = 4;
  localparam int unsigned Rows    = Degree / RowBits;
  localparam int unsigned RowW    = PosW - RowSelW;

  localparam logic [CoeffW-1:0] ModulusReset = 63'd549824583172097;

  localparam logic KindCoeff  = 1'b0;
  localparam logic KindRehash = 1'b1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_of_challenge;
  } in_t;

  typedef struct packed {
    logic              result_kind;
    logic [PosW-1:0]   coeff_position;
    logic [CoeffW-1:0] coeff_value;
    logic [CountW-1:0] placed_count;
    logic              last;
  } out_t;

endpackage

/* rtl/core/stcs_ram.sv */
// stcs_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module stcs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sparse_ternary_challenge_sampler.sv */
// sparse_ternary_challenge_sampler: places +1/-1 challenge coefficients from hash bytes
// depends on stcs_pkg and stcs_ram (occupancy rows)
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  in       | to block  | in_valid_i / in_stall_o | stcs_pkg::in_t (one hash byte)
//  out      | from block| out_valid_o / out_stall_i| stcs_pkg::out_t (placement or rehash)
//  cfg      | to block  | cfg_we_i                | modulus_q, 63 bits
//
// one byte is taken per cycle unless stalled; a pair reads its occupancy row in the accept
// cycle and checks, writes back and queues its results in the next cycle
// results leave through an OutDepth-entry queue; the input stalls only on the second
// byte of a pair when the queue could not take two more results
// reset is asynchronous; row valid bits clear the occupancy store at once, so no
// clearing pass is needed, and a first_of_challenge byte clears it the same way
module sparse_ternary_challenge_sampler #(
  parameter int unsigned OutDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  stcs_pkg::in_t        in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output stcs_pkg::out_t       out_data_o,
  input  logic                 cfg_we_i,
  input  logic [62:0]          cfg_wdata_i
);

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);
  localparam int unsigned IdxW = stcs_pkg::IdxW;
  localparam int unsigned CW   = stcs_pkg::CountW;

  // configuration
  logic [stcs_pkg::CoeffW-1:0] modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= stcs_pkg::ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // challenge state
  logic [63:0]     sign_q, sign_d;
  logic [CW-1:0]   placed_q, placed_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      low_q, low_d;
  logic            first_buf_q, first_buf_d;
  logic            fin_q, fin_d;
  logic [stcs_pkg::Rows-1:0] row_valid_q, row_valid_d;

  // stage 2 registers
  logic                        s2_valid_q;
  logic [stcs_pkg::PosW-1:0]   s2_pos_q;
  logic                        s2_exh_q;
  logic                        s2_row_valid_q;

  // output queue
  stcs_pkg::out_t  oq_q [OutDepth];
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0] cnt_q;

  // stage 1: byte classification
  logic            accept, clr;
  logic [IdxW-1:0] eff_idx, idx_inc, pair_off;
  logic            eff_first, eff_fin;
  logic            is_sign, is_low, is_high, exhaust;
  logic [stcs_pkg::PosW-1:0] pos1;
  logic            rd_en;

  assign accept = in_valid_i && !in_stall_o;
  assign clr    = accept && in_data_i.first_of_challenge;

  always_comb begin
    eff_idx   = clr ? '0 : idx_q;
    eff_first = clr ? 1'b1 : first_buf_q;
    eff_fin   = clr ? 1'b0 : fin_q;
    is_sign   = eff_first && (eff_idx < IdxW'(stcs_pkg::SignBytes));
    pair_off  = eff_idx - (eff_first ? IdxW'(stcs_pkg::SignBytes) : '0);
    is_low    = !is_sign && !pair_off[0];
    is_high   = !is_sign && pair_off[0];
    idx_inc   = eff_idx + IdxW'(1);
    exhaust   = is_high && (idx_inc >= IdxW'(stcs_pkg::BufferBytes - 1));
  end

  // position is the 16-bit pair mod 512
  assign pos1  = {in_data_i.byte_value[0], low_q};
  assign rd_en = accept && !eff_fin && is_high;

  // stage 2: occupancy check
  logic [stcs_pkg::RowBits-1:0] row_rdata, row_cur, row_wdata;
  logic                         occupied, place, fin_new, push_rehash;
  logic [CW-1:0]                placed_inc;
  logic [stcs_pkg::CoeffW-1:0]  coeff_val;
  logic                         ram_we;
  stcs_pkg::out_t               res_coeff, res_rehash;

  stcs_ram #(
    .Width (stcs_pkg::RowBits),
    .Depth (stcs_pkg::Rows)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_pos_q[stcs_pkg::PosW-1:stcs_pkg::RowSelW]),
    .wdata_i (row_wdata),
    .re_i    (rd_en),
    .raddr_i (pos1[stcs_pkg::PosW-1:stcs_pkg::RowSelW]),
    .rdata_o (row_rdata)
  );

  always_comb begin
    row_cur    = s2_row_valid_q ? row_rdata : '0;
    occupied   = row_cur[s2_pos_q[stcs_pkg::RowSelW-1:0]];
    place      = s2_valid_q && !occupied;
    placed_inc = placed_q + CW'(1);
    fin_new    = place && (placed_inc >= CW'(stcs_pkg::Weight));
    row_wdata  = row_cur;
    row_wdata[s2_pos_q[stcs_pkg::RowSelW-1:0]] = 1'b1;
    // a clearing byte in the same cycle drops the old challenge's write
    ram_we     = place && !clr;
    coeff_val  = sign_q[0] ? (modulus_q - stcs_pkg::CoeffW'(1)) : stcs_pkg::CoeffW'(1);
    push_rehash = s2_valid_q && s2_exh_q && !fin_new;

    res_coeff.result_kind    = stcs_pkg::KindCoeff;
    res_coeff.coeff_position = s2_pos_q;
    res_coeff.coeff_value    = coeff_val;
    res_coeff.placed_count   = placed_inc;
    res_coeff.last           = fin_new;

    res_rehash.result_kind    = stcs_pkg::KindRehash;
    res_rehash.coeff_position = '0;
    res_rehash.coeff_value    = '0;
    res_rehash.placed_count   = place ? placed_inc : placed_q;
    res_rehash.last           = 1'b0;
  end

  // next state
  always_comb begin
    sign_d      = place ? (sign_q >> 1) : sign_q;
    placed_d    = place ? placed_inc : placed_q;
    fin_d       = fin_q || fin_new;
    row_valid_d = row_valid_q;
    if (ram_we) begin
      row_valid_d[s2_pos_q[stcs_pkg::PosW-1:stcs_pkg::RowSelW]] = 1'b1;
    end
    idx_d       = idx_q;
    first_buf_d = first_buf_q;
    low_d       = low_q;
    if (clr) begin
      sign_d      = '0;
      placed_d    = '0;
      fin_d       = 1'b0;
      row_valid_d = '0;
      idx_d       = '0;
      first_buf_d = 1'b1;
      low_d       = '0;
    end
    if (accept && !eff_fin) begin
      idx_d       = exhaust ? '0 : idx_inc;
      first_buf_d = exhaust ? 1'b0 : eff_first;
      if (is_sign) begin
        sign_d[{eff_idx[2:0], 3'b000} +: 8] = in_data_i.byte_value;
      end
      if (is_low) begin
        low_d = in_data_i.byte_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q         <= '0;
      placed_q       <= '0;
      fin_q          <= 1'b0;
      row_valid_q    <= '0;
      idx_q          <= '0;
      first_buf_q    <= 1'b1;
      low_q          <= '0;
      s2_valid_q     <= 1'b0;
      s2_pos_q       <= '0;
      s2_exh_q       <= 1'b0;
      s2_row_valid_q <= 1'b0;
    end else begin
      sign_q         <= sign_d;
      placed_q       <= placed_d;
      fin_q          <= fin_d;
      row_valid_q    <= row_valid_d;
      idx_q          <= idx_d;
      first_buf_q    <= first_buf_d;
      low_q          <= low_d;
      s2_valid_q     <= rd_en;
      s2_pos_q       <= pos1;
      s2_exh_q       <= exhaust;
      s2_row_valid_q <= row_valid_q[pos1[stcs_pkg::PosW-1:stcs_pkg::RowSelW]];
    end
  end

  // output queue, up to two pushes per cycle
  logic            pop;
  logic [1:0]      n_push;
  logic [PtrW-1:0] wr_ptr_nx;
  logic            next_pair;
  logic [IdxW-1:0] st_off;
  logic [CntW:0]   worst_cnt;

  assign pop       = out_valid_o && !out_stall_i;
  assign n_push    = {1'b0, place} + {1'b0, push_rehash};
  assign wr_ptr_nx = (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (n_push == 2'd2) begin
        wr_ptr_q <= (wr_ptr_nx == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_nx + PtrW'(1);
      end else if (n_push == 2'd1) begin
        wr_ptr_q <= wr_ptr_nx;
      end
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      oq_q[wr_ptr_q] <= place ? res_coeff : res_rehash;
    end
    if (n_push == 2'd2) begin
      oq_q[wr_ptr_nx] <= res_rehash;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = oq_q[rd_ptr_q];

  // only the second byte of a pair makes results; hold it off when the queue could overflow
  always_comb begin
    st_off    = idx_q - (first_buf_q ? IdxW'(stcs_pkg::SignBytes) : '0);
    next_pair = !fin_q && !(first_buf_q && (idx_q < IdxW'(stcs_pkg::SignBytes)))
                && st_off[0];
    worst_cnt = {1'b0, cnt_q} + (s2_valid_q ? (CntW+1)'(2) : '0);
  end

  assign in_stall_o = next_pair && (worst_cnt > (CntW+1)'(OutDepth - 2));

endmodule
